// ===== rtl/core/line_rasterizer_color_interp_assert.svh =====
// Assertion macros for the line rasterizer.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef LINE_RASTERIZER_COLOR_INTERP_ASSERT_SVH
`define LINE_RASTERIZER_COLOR_INTERP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lcic_pkg.sv =====
`timescale 1ns / 1ps

package lcic_pkg;

	localparam int COORD_W         = 9;
	localparam int MAJOR_W         = 10;
	localparam int CHAN_W          = 8;
	localparam int ADDR_W          = 20;
	localparam int DEC_W           = 12;
	localparam int EAST_W          = 11;
	localparam int SCREEN_SIZE_DEF = 512;
	localparam int DIV_CNT_W       = $clog2(CHAN_W);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(CHAN_W - 1);
	localparam logic [CHAN_W-1:0]    COLOR_OPAQUE  = '1;

	// command codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [CHAN_W-1:0]  start_red;
		logic [CHAN_W-1:0]  start_green;
		logic [CHAN_W-1:0]  start_blue;
		logic [CHAN_W-1:0]  start_alpha;
		logic [CHAN_W-1:0]  end_red;
		logic [CHAN_W-1:0]  end_green;
		logic [CHAN_W-1:0]  end_blue;
	} lcic_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [ADDR_W-1:0]  pixel_address;
		logic [CHAN_W-1:0]  pixel_red;
		logic [CHAN_W-1:0]  pixel_green;
		logic [CHAN_W-1:0]  pixel_blue;
		logic [CHAN_W-1:0]  pixel_alpha;
		logic               last_pixel;
	} lcic_pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} lcic_rgb_t;

	// line set-up; decision and diagonal increment are two's complement
	typedef struct packed {
		logic [COORD_W-1:0] major_pos;
		logic [COORD_W-1:0] minor_pos;
		logic [COORD_W-1:0] major_end;
		logic [COORD_W-1:0] major_span;
		logic [DEC_W-1:0]   decision;
		logic [EAST_W-1:0]  east_inc;
		logic [DEC_W-1:0]   diag_inc;
		logic               axes_swapped;
		logic               minor_down;
		lcic_rgb_t          cur_rgb;
		lcic_rgb_t          tgt_rgb;
		logic [CHAN_W-1:0]  alpha;
	} lcic_line_t;

	typedef struct packed {
		logic start;
		logic shift;
	} lcic_div_ctrl_t;

	typedef enum logic [1:0] {
		ST_READY,
		ST_DIVIDE,
		ST_WRITE
	} lcic_state_t;

endpackage

// ===== rtl/core/lcic_setup.sv =====
`timescale 1ns / 1ps

module lcic_setup import lcic_pkg::*; (
	input  lcic_cmd_t  cmd,
	output lcic_line_t setup_line
);

	logic [COORD_W:0]   dx_raw, dy_raw, dmaj, dmin;
	logic [COORD_W-1:0] adx, ady, a0, a1, b0, b1, span, dmin_abs;
	logic               swapped, reverse, down;
	lcic_rgb_t          rgb_start, rgb_end;

	always_comb begin
		dx_raw  = {1'b0, cmd.end_x} - {1'b0, cmd.start_x};
		dy_raw  = {1'b0, cmd.end_y} - {1'b0, cmd.start_y};
		adx     = dx_raw[COORD_W] ? COORD_W'(-dx_raw) : dx_raw[COORD_W-1:0];
		ady     = dy_raw[COORD_W] ? COORD_W'(-dy_raw) : dy_raw[COORD_W-1:0];
		// steep line: y becomes the major axis; a tie stays on x
		swapped = adx < ady;
		a0      = swapped ? cmd.start_y : cmd.start_x;
		b0      = swapped ? cmd.start_x : cmd.start_y;
		a1      = swapped ? cmd.end_y   : cmd.end_x;
		b1      = swapped ? cmd.end_x   : cmd.end_y;
		// walk always runs up the major axis: trade end points if needed
		dmaj    = {1'b0, a1} - {1'b0, a0};
		reverse = dmaj[COORD_W];
		span    = reverse ? COORD_W'(-dmaj) : dmaj[COORD_W-1:0];
		dmin    = reverse ? ({1'b0, b0} - {1'b0, b1}) : ({1'b0, b1} - {1'b0, b0});
		down    = dmin[COORD_W];
		dmin_abs = down ? COORD_W'(-dmin) : dmin[COORD_W-1:0];

		rgb_start = '{red: cmd.start_red, green: cmd.start_green, blue: cmd.start_blue};
		rgb_end   = '{red: cmd.end_red,   green: cmd.end_green,   blue: cmd.end_blue};

		setup_line.major_pos    = reverse ? a1 : a0;
		setup_line.minor_pos    = reverse ? b1 : b0;
		setup_line.major_end    = reverse ? a0 : a1;
		setup_line.major_span   = span;
		setup_line.decision     = DEC_W'({dmin_abs, 1'b0}) - DEC_W'(span);
		setup_line.east_inc     = EAST_W'({dmin_abs, 1'b0});
		setup_line.diag_inc     = DEC_W'({dmin_abs, 1'b0}) - DEC_W'({span, 1'b0});
		setup_line.axes_swapped = swapped;
		setup_line.minor_down   = down;
		setup_line.cur_rgb      = reverse ? rgb_end   : rgb_start;
		setup_line.tgt_rgb      = reverse ? rgb_start : rgb_end;
		setup_line.alpha        = cmd.start_alpha;
	end

endmodule

// ===== rtl/core/lcic_div_lane.sv =====
`timescale 1ns / 1ps

module lcic_div_lane import lcic_pkg::*; (
	input  logic               clk,
	input  lcic_div_ctrl_t     ctrl,
	input  logic [CHAN_W-1:0]  cur,
	input  logic [CHAN_W-1:0]  tgt,
	input  logic [COORD_W-1:0] span,
	output logic [CHAN_W-1:0]  result
);

	logic [CHAN_W-1:0]  cur_q, num_q;
	logic [COORD_W-1:0] rem_q, rem_next;
	logic               neg_q, q_bit;
	logic [COORD_W:0]   trial;

	// restoring division, one quotient bit per cycle; num_q turns into the quotient
	always_comb begin
		trial    = {rem_q, num_q[CHAN_W-1]};
		q_bit    = trial >= {1'b0, span};
		rem_next = q_bit ? COORD_W'(trial - {1'b0, span}) : trial[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			cur_q <= cur;
			neg_q <= tgt < cur;
			num_q <= (tgt < cur) ? (cur - tgt) : (tgt - cur);
			rem_q <= '0;
		end else if (ctrl.shift) begin
			rem_q <= rem_next;
			num_q <= {num_q[CHAN_W-2:0], q_bit};
		end
	end

	// floor rounding: a negative quotient with a remainder drops one more
	assign result = neg_q ? (cur_q - num_q - CHAN_W'(|rem_q)) : (cur_q + num_q);

endmodule

// ===== rtl/core/line_rasterizer_color_interp.sv =====
// Bresenham line rasterizer with per-pixel colour interpolation.
// Command channel (cmd_valid / cmd_ready / cmd): a load beat sets up a line from
// its two end points and colours and gives no pixel; a step beat asks for the
// next pixel of the active line. A step while no line is active is dropped.
// Pixel channel (pixel_valid / pixel_ready / pixel): one beat per step with the
// coordinates, byte address 4*(x + y*SCREEN_SIZE), colour and a last flag. A line
// yields max(span, 1) pixels and, unless its span is zero, leaves out its end point.
// A pixel is registered and shown in the cycle after its step beat is taken.
// After a step the three colour channels are advanced by three bit-serial
// dividers working side by side, one quotient bit per cycle; the sequencer runs
// its divide state, then its write-back state, and takes no command until it is
// ready again; a zero-span step, a load and a dropped step skip the divide.
// The pixel register lets the next step's work run while a pixel waits; a
// stalled receiver holds the pixel and blocks only the next step or load.
// Reset clears the active flag, the sequencer and the pixel valid; no line is
// active until the first load.
`timescale 1ns / 1ps
`include "line_rasterizer_color_interp_assert.svh"

module line_rasterizer_color_interp import lcic_pkg::*; #(
	parameter int SCREEN_SIZE = SCREEN_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  lcic_cmd_t   cmd,
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output lcic_pixel_t pixel
);

	lcic_state_t           state_q, state_next;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  busy_q;
	logic                  pixel_valid_q;
	lcic_pixel_t           pixel_q, pixel_build;

	// line state
	logic [MAJOR_W-1:0]    major_pos_q;
	logic [COORD_W-1:0]    minor_pos_q, major_end_q, span_q;
	logic [DEC_W-1:0]      dec_q, diag_q;
	logic [EAST_W-1:0]     east_q;
	logic                  axes_swapped_q, minor_down_q;
	lcic_rgb_t             cur_rgb_q, tgt_rgb_q, next_rgb;
	logic [CHAN_W-1:0]     alpha_q;

	lcic_line_t            setup_line;
	lcic_div_ctrl_t        div_ctrl;

	logic                  cmd_fire, load_fire, step_fire, need_div, last_pix;
	logic [COORD_W-1:0]    px, py;
	logic [ADDR_W-1:0]     row_off;

	lcic_setup u_setup (
		.cmd        (cmd),
		.setup_line (setup_line)
	);

	lcic_div_lane u_div_red (
		.clk    (clk),
		.ctrl   (div_ctrl),
		.cur    (cur_rgb_q.red),
		.tgt    (tgt_rgb_q.red),
		.span   (span_q),
		.result (next_rgb.red)
	);

	lcic_div_lane u_div_green (
		.clk    (clk),
		.ctrl   (div_ctrl),
		.cur    (cur_rgb_q.green),
		.tgt    (tgt_rgb_q.green),
		.span   (span_q),
		.result (next_rgb.green)
	);

	lcic_div_lane u_div_blue (
		.clk    (clk),
		.ctrl   (div_ctrl),
		.cur    (cur_rgb_q.blue),
		.tgt    (tgt_rgb_q.blue),
		.span   (span_q),
		.result (next_rgb.blue)
	);

	// Command decode. Only a step on an active line makes a pixel, and only a
	// non-zero span needs the dividers.
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign load_fire = cmd_fire && (cmd.operation == OP_LOAD);
	assign step_fire = cmd_fire && (cmd.operation == OP_STEP) && busy_q;
	assign need_div  = step_fire && (span_q != '0);

	// Next state: divide until the quotient has a bit for every channel bit, then write back.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_READY:  if (need_div) state_next = ST_DIVIDE;
			ST_DIVIDE: if (div_cnt_q == DIV_LAST) state_next = ST_WRITE;
			ST_WRITE:  state_next = ST_READY;
			default:   state_next = ST_READY;
		endcase
	end

	// Outputs: take a command only with the pixel register free or draining.
	always_comb begin
		cmd_ready      = 1'b0;
		div_ctrl.start = 1'b0;
		div_ctrl.shift = 1'b0;
		unique case (state_q)
			ST_READY: begin
				cmd_ready      = !pixel_valid_q || pixel_ready;
				div_ctrl.start = need_div;
			end
			ST_DIVIDE: div_ctrl.shift = 1'b1;
			ST_WRITE:  ;
			default:   ;
		endcase
	end

	// Pixel assembly from the current walk position.
	always_comb begin
		px       = axes_swapped_q ? minor_pos_q : major_pos_q[COORD_W-1:0];
		py       = axes_swapped_q ? major_pos_q[COORD_W-1:0] : minor_pos_q;
		row_off  = ADDR_W'(py) * ADDR_W'(SCREEN_SIZE);
		last_pix = ({1'b0, major_pos_q} + (MAJOR_W + 1)'(1)) >=
			(MAJOR_W + 1)'(major_end_q);

		pixel_build.pixel_x       = px;
		pixel_build.pixel_y       = py;
		pixel_build.pixel_address = (ADDR_W'(px) + row_off) << 2;
		pixel_build.pixel_red     = cur_rgb_q.red;
		pixel_build.pixel_green   = cur_rgb_q.green;
		pixel_build.pixel_blue    = cur_rgb_q.blue;
		pixel_build.pixel_alpha   = alpha_q;
		pixel_build.last_pixel    = last_pix;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_READY;
			div_cnt_q     <= '0;
			busy_q        <= 1'b0;
			pixel_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_DIVIDE) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (load_fire) begin
				busy_q <= 1'b1;
			end else if (step_fire && last_pix) begin
				busy_q <= 1'b0;
			end
			if (step_fire) begin
				pixel_valid_q <= 1'b1;
			end else if (pixel_ready) begin
				pixel_valid_q <= 1'b0;
			end
		end
	end

	// Line state and pixel register.
	always_ff @(posedge clk) begin
		if (load_fire) begin
			major_pos_q    <= MAJOR_W'(setup_line.major_pos);
			minor_pos_q    <= setup_line.minor_pos;
			major_end_q    <= setup_line.major_end;
			span_q         <= setup_line.major_span;
			dec_q          <= setup_line.decision;
			east_q         <= setup_line.east_inc;
			diag_q         <= setup_line.diag_inc;
			axes_swapped_q <= setup_line.axes_swapped;
			minor_down_q   <= setup_line.minor_down;
			cur_rgb_q      <= setup_line.cur_rgb;
			tgt_rgb_q      <= setup_line.tgt_rgb;
			alpha_q        <= setup_line.alpha;
		end else if (step_fire) begin
			pixel_q     <= pixel_build;
			major_pos_q <= major_pos_q + MAJOR_W'(1);
			alpha_q     <= COLOR_OPAQUE;
			// advance east while the decision is not positive, else diagonal
			if ($signed(dec_q) <= 0) begin
				dec_q <= dec_q + DEC_W'(east_q);
			end else begin
				dec_q       <= dec_q + diag_q;
				minor_pos_q <= minor_down_q ? (minor_pos_q - COORD_W'(1))
					: (minor_pos_q + COORD_W'(1));
			end
		end else if (state_q == ST_WRITE) begin
			cur_rgb_q <= next_rgb;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	`LCIC_ASSERT_NEXT(a_div_entered, need_div, state_q == ST_DIVIDE, "divide not started")
	`LCIC_ASSERT_NEXT(a_last_ends_line, step_fire && last_pix, !busy_q, "line active after last")
	`LCIC_ASSERT_NOW(a_pixel_from_step, $rose(pixel_valid), $past(step_fire), "pixel without step")
	`LCIC_ASSERT_NOW(a_write_count, state_q == ST_WRITE, div_cnt_q == '0, "bad divide count")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Line rasterizer bench.
// Drive load and step beats into the command channel and collect pixel beats.
// Run a line model of our own alongside and queue one expected pixel for every
// step beat that lands on an active line. Compare every pixel beat with the
// oldest queued pixel, field by field.
module testbench;
	import lcic_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int LONG_HOLD   = 200;   // receiver hold-off that fills the block
	localparam int DRAIN_WAIT  = 20;    // covers a step still in its divide and write-back
	localparam int STALL_LIMIT = 4000;  // cycles with no beat on either channel
	localparam int SHOW_MAX    = 10;

	typedef struct {
		lcic_cmd_t   cmd;
		bit          has_lit;
		lcic_pixel_t lit;
	} dir_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cmd_valid   = 1'b0;
	logic        cmd_ready;
	lcic_cmd_t   cmd         = '0;
	logic        pixel_valid;
	logic        pixel_ready = 1'b0;
	lcic_pixel_t pixel;

	// Line state as the block should hold it
	bit ln_busy;
	int ln_major;      // runs on 10 bits, may pass the end point by one
	int ln_minor;
	int ln_end;
	int ln_dec;
	int ln_east;
	int ln_diag;
	int ln_span;
	bit ln_swapped;
	bit ln_down;
	int col_cur[3];    // red, green, blue
	int col_tgt[3];
	int col_alpha;

	lcic_pixel_t pixels_due[$];
	dir_row_t    dir_rows[$];

	int  fail_count     = 0;
	int  effective_items = 0;
	int  idle_cycles    = 0;
	bit  hold_req       = 1'b0;
	int  send_run       = 0;
	int  recv_run       = 0;

	always #5 clk = ~clk;

	line_rasterizer_color_interp DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel)
	);

	function automatic int floor_quot(int num, int den);
		int q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < 0)
			return 0;
		if (v > 511)
			return 511;
		return v;
	endfunction

	// Colour channels lean on the extremes a third of the time
	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom());
		endcase
	endfunction

	function automatic lcic_cmd_t rand_cmd();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(lcic_cmd_t)-1:0];
	endfunction

	function automatic lcic_cmd_t make_cmd(logic op, int x0, int y0, int x1, int y1,
			int r0, int g0, int b0, int a0, int r1, int g1, int b1);
		lcic_cmd_t c;
		c.operation   = op;
		c.start_x     = COORD_W'(x0);
		c.start_y     = COORD_W'(y0);
		c.end_x       = COORD_W'(x1);
		c.end_y       = COORD_W'(y1);
		c.start_red   = CHAN_W'(r0);
		c.start_green = CHAN_W'(g0);
		c.start_blue  = CHAN_W'(b0);
		c.start_alpha = CHAN_W'(a0);
		c.end_red     = CHAN_W'(r1);
		c.end_green   = CHAN_W'(g1);
		c.end_blue    = CHAN_W'(b1);
		return c;
	endfunction

	function automatic lcic_pixel_t make_pixel(int x, int y, int addr,
			int r, int g, int b, int a, bit is_last);
		lcic_pixel_t p;
		p.pixel_x       = COORD_W'(x);
		p.pixel_y       = COORD_W'(y);
		p.pixel_address = ADDR_W'(addr);
		p.pixel_red     = CHAN_W'(r);
		p.pixel_green   = CHAN_W'(g);
		p.pixel_blue    = CHAN_W'(b);
		p.pixel_alpha   = CHAN_W'(a);
		p.last_pixel    = is_last;
		return p;
	endfunction

	// Idle draw: a random idle gap between beats, with the odd run of back-to-back beats
	function automatic int draw_wait(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	// Set up a line: swap axes on a steep line, then swap ends (and colours,
	// alpha excepted) when the major delta runs backwards.
	task automatic line_setup(input lcic_cmd_t c);
		int x0, y0, x1, y1, dx, dy, t;
		int c0[3], c1[3];
		x0 = int'(c.start_x);
		y0 = int'(c.start_y);
		x1 = int'(c.end_x);
		y1 = int'(c.end_y);
		c0 = '{int'(c.start_red), int'(c.start_green), int'(c.start_blue)};
		c1 = '{int'(c.end_red), int'(c.end_green), int'(c.end_blue)};
		dx = x1 - x0;
		dy = y1 - y0;
		ln_swapped = ((dx < 0) ? -dx : dx) < ((dy < 0) ? -dy : dy);
		if (ln_swapped) begin
			t = x0; x0 = y0; y0 = t;
			t = x1; x1 = y1; y1 = t;
		end
		dx = x1 - x0;
		if (dx < 0) begin
			for (int k = 0; k < 3; k++) begin
				t = c0[k]; c0[k] = c1[k]; c1[k] = t;
			end
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
			dx = -dx;
		end
		dy = y1 - y0;
		ln_down = dy < 0;
		if (dy < 0)
			dy = -dy;
		ln_major  = x0;
		ln_minor  = y0;
		ln_end    = x1;
		ln_span   = dx;
		ln_dec    = 2 * dy - dx;
		ln_east   = 2 * dy;
		ln_diag   = 2 * (dy - dx);
		col_cur   = c0;
		col_tgt   = c1;
		col_alpha = int'(c.start_alpha);
		ln_busy   = 1'b1;
	endtask

	// Apply one accepted command to the line state; give the pixel it yields
	task automatic raster_model(input lcic_cmd_t c, output bit emitted, output lcic_pixel_t p);
		int px, py, addr;
		bit is_last;
		emitted = 1'b0;
		p = '0;
		if (c.operation == OP_LOAD) begin
			line_setup(c);
			return;
		end
		if (!ln_busy)
			return;
		px = (ln_swapped ? ln_minor : ln_major) & 'h1FF;
		py = (ln_swapped ? ln_major : ln_minor) & 'h1FF;
		addr = (4 * (px + py * SCREEN_SIZE_DEF)) & 'hFFFFF;
		is_last = (ln_major + 1) >= ln_end;
		p = make_pixel(px, py, addr, col_cur[0], col_cur[1], col_cur[2], col_alpha, is_last);
		emitted = 1'b1;

		if (ln_dec <= 0) begin
			ln_dec = ln_dec + ln_east;
		end else begin
			ln_dec = ln_dec + ln_diag;
			ln_minor = (ln_down ? ln_minor - 1 : ln_minor + 1) & 'h1FF;
		end
		ln_major = (ln_major + 1) & 'h3FF;

		// zero span: colour holds, nothing is divided
		if (ln_span != 0) begin
			for (int k = 0; k < 3; k++) begin
				col_cur[k] = col_cur[k] + floor_quot(col_tgt[k] - col_cur[k], ln_span);
				if (col_cur[k] < 0)
					col_cur[k] = 0;
				if (col_cur[k] > 255)
					col_cur[k] = 255;
			end
		end
		col_alpha = 255;
		if (is_last)
			ln_busy = 1'b0;
	endtask

	// Offer one command beat and hold it until taken. A literal, where given,
	// stands in for the model's pixel.
	task automatic send_cmd(input lcic_cmd_t c, input bit has_lit, input lcic_pixel_t lit);
		int gap;
		bit emitted;
		lcic_pixel_t p;
		gap = draw_wait(send_run);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		raster_model(c, emitted, p);
		if (emitted)
			pixels_due.push_back(has_lit ? lit : p);
		// steps that fall on an idle block do not count
		if (c.operation == OP_LOAD || emitted)
			effective_items++;
	endtask

	task automatic send_step();
		lcic_cmd_t c;
		c = rand_cmd();
		c.operation = OP_STEP;
		send_cmd(c, 1'b0, '0);
	endtask

	// Receiver: stall at random between beats; take one long hold-off on request
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pixel_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = draw_wait(recv_run);
				if (stall > 0) begin
					pixel_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			pixel_ready <= 1'b1;
			@(posedge clk);
			while (!pixel_valid)
				@(posedge clk);
		end
	end

	// Check each pixel beat against the oldest expected pixel
	always @(posedge clk) begin
		lcic_pixel_t want;
		bit differs;
		if (arst_n && pixel_valid && pixel_ready) begin
			if (pixels_due.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOW_MAX)
					$display("pixel beat with none expected: %p", pixel);
			end else begin
				want = pixels_due.pop_front();
				differs = (pixel.pixel_x !== want.pixel_x)
					|| (pixel.pixel_y !== want.pixel_y)
					|| (pixel.pixel_address !== want.pixel_address)
					|| (pixel.pixel_red !== want.pixel_red)
					|| (pixel.pixel_green !== want.pixel_green)
					|| (pixel.pixel_blue !== want.pixel_blue)
					|| (pixel.pixel_alpha !== want.pixel_alpha)
					|| (pixel.last_pixel !== want.last_pixel);
				if (differs) begin
					fail_count++;
					if (fail_count <= SHOW_MAX)
						$display("pixel mismatch at %0t\n  expected %p\n  actual   %p",
							$realtime, want, pixel);
				end
			end
		end
	end

	// Watchdog: give up once neither channel has moved for too long
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (pixel_valid && pixel_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		lcic_cmd_t c;
		int kind, partial;
		bit hold_done, pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		// Directed rows. Literal pixels only where they are plain to see.
		// step on an idle block: dropped
		dir_rows.push_back('{make_cmd(OP_STEP, 5, 5, 6, 6, 1, 2, 3, 4, 5, 6, 7), 0, '0});
		// zero-length line in the far corner: one pixel, flagged last, top address
		dir_rows.push_back('{make_cmd(OP_LOAD, 511, 511, 511, 511, 255, 0, 128, 7,
			9, 9, 9), 0, '0});
		dir_rows.push_back('{make_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			make_pixel(511, 511, 'hFFFFC, 255, 0, 128, 7, 1'b1)});
		dir_rows.push_back('{make_cmd(OP_STEP, 511, 511, 511, 511, 255, 255, 255, 255,
			255, 255, 255), 0, '0});
		// span of one at the origin
		dir_rows.push_back('{make_cmd(OP_LOAD, 0, 0, 1, 0, 10, 20, 30, 40, 200, 100, 50),
			0, '0});
		dir_rows.push_back('{make_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			make_pixel(0, 0, 0, 10, 20, 30, 40, 1'b1)});
		// steep and backwards: ends and colours trade places, alpha stays
		dir_rows.push_back('{make_cmd(OP_LOAD, 0, 1, 0, 0, 1, 2, 3, 99, 250, 251, 252),
			0, '0});
		dir_rows.push_back('{make_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			make_pixel(0, 0, 0, 250, 251, 252, 99, 1'b1)});
		// full-screen anti-diagonal, cut short by the next load
		dir_rows.push_back('{make_cmd(OP_LOAD, 0, 511, 511, 0, 255, 255, 255, 0, 0, 0, 0),
			0, '0});
		repeat (3)
			dir_rows.push_back('{make_cmd(OP_STEP, 511, 0, 0, 511, 0, 0, 0, 0, 0, 0, 0),
				0, '0});
		// steep, minor axis stepping down
		dir_rows.push_back('{make_cmd(OP_LOAD, 300, 10, 290, 40, 0, 128, 255, 200,
			255, 128, 0), 0, '0});
		repeat (3)
			dir_rows.push_back('{make_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
		// exact diagonal: no axis swap, run to the end, then one step too many
		dir_rows.push_back('{make_cmd(OP_LOAD, 0, 0, 3, 3, 0, 255, 17, 255, 255, 0, 200),
			0, '0});
		repeat (4)
			dir_rows.push_back('{make_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].has_lit, dir_rows[i].lit);

		// Random part: mostly whole lines with random content, some noise
		while (effective_items < ITEM_TARGET) begin
			// hold the receiver off mid-run so the block backs up
			if (!hold_done && effective_items >= 600) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			// pause the sender until every pixel is home
			if (!pause_done && effective_items >= 1200) begin
				cmd_valid <= 1'b0;
				while (pixels_due.size() != 0)
					@(posedge clk);
				repeat (DRAIN_WAIT) @(posedge clk);
				pause_done = 1'b1;
			end

			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				send_cmd(rand_cmd(), 1'b0, '0);
			end else begin
				c = rand_cmd();
				c.operation = OP_LOAD;
				// a rare full-range line, otherwise a short one around a random start
				if (kind >= 12) begin
					c.end_x = COORD_W'(clamp_coord(int'(c.start_x)
						+ int'($urandom_range(0, 24)) - 12));
					c.end_y = COORD_W'(clamp_coord(int'(c.start_y)
						+ int'($urandom_range(0, 24)) - 12));
				end
				c.start_red   = rand_chan();
				c.start_green = rand_chan();
				c.start_blue  = rand_chan();
				c.start_alpha = rand_chan();
				c.end_red     = rand_chan();
				c.end_green   = rand_chan();
				c.end_blue    = rand_chan();
				send_cmd(c, 1'b0, '0);
				if (kind >= 12 && $urandom_range(0, 4) == 0) begin
					// broken off: the next load restarts the block
					partial = $urandom_range(0, 3);
					repeat (partial)
						send_step();
				end else begin
					while (ln_busy)
						send_step();
				end
				if ($urandom_range(0, 5) == 0)
					send_step();
			end
		end

		// Drain, then allow for a step still turning over inside the block
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
